### src/salb_pkg.sv
// salb_pkg: shared types for the suffix array / lcp builder
// sequencer step codes and the command and status structs between controller and datapath
// no dependencies
package salb_pkg;

  // fixed widths of the external payload
  localparam int unsigned SymInW = 8;
  localparam int unsigned OutW   = 6;

  typedef enum logic [5:0] {
    ST_LOAD,
    ST_A_RD,
    ST_A_LATCH,
    ST_A_SCAN,
    ST_A_WR,
    ST_CHK_RD,
    ST_CHK_RANK,
    ST_CHK_TEST,
    ST_TAIL,
    ST_SHIFT,
    ST_CLR,
    ST_CNT_RD,
    ST_CNT_BK,
    ST_CNT_WR,
    ST_SUM_RD,
    ST_SUM_WR,
    ST_PL_RD,
    ST_PL_RANK,
    ST_PL_BK,
    ST_PL_WR,
    ST_COPY,
    ST_RK_RD,
    ST_RK_A,
    ST_RK_B,
    ST_RK_WR,
    ST_KS_RD,
    ST_KS_R,
    ST_KS_P,
    ST_KS_T0,
    ST_KS_T1,
    ST_KS_T2,
    ST_KS_WR,
    ST_OUT_WAIT,
    ST_OUT_LOAD
  } state_e;

  typedef struct packed {
    state_e step;
  } cmd_t;

  typedef struct packed {
    logic in_fire;
    logic in_final;
    logic i_last;
    logic k_last;
    logic scan_done;
    logic sorted;
    logic rank_zero;
    logic ext_ok;
    logic sym_eq;
    logic out_busy;
  } sts_t;

endpackage

### src/salb_ram.sv
// salb_ram: generic single-write, single-read ram with registered read data
// depends on nothing
module salb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/salb_ctrl.sv
// salb_ctrl: sequencer for load, ranking, doubling rounds, kasai pass and drain
// depends on salb_pkg
module salb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  salb_pkg::sts_t sts_i,
  output salb_pkg::cmd_t cmd_o
);

  salb_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      salb_pkg::ST_LOAD:     if (sts_i.in_fire && sts_i.in_final) state_d = salb_pkg::ST_A_RD;
      salb_pkg::ST_A_RD:     state_d = salb_pkg::ST_A_LATCH;
      salb_pkg::ST_A_LATCH:  state_d = salb_pkg::ST_A_SCAN;
      salb_pkg::ST_A_SCAN:   if (sts_i.scan_done) state_d = salb_pkg::ST_A_WR;
      salb_pkg::ST_A_WR: begin
        state_d = sts_i.i_last ? salb_pkg::ST_CHK_RD : salb_pkg::ST_A_RD;
      end
      salb_pkg::ST_CHK_RD:   state_d = salb_pkg::ST_CHK_RANK;
      salb_pkg::ST_CHK_RANK: state_d = salb_pkg::ST_CHK_TEST;
      salb_pkg::ST_CHK_TEST: begin
        state_d = sts_i.sorted ? salb_pkg::ST_KS_RD : salb_pkg::ST_TAIL;
      end
      salb_pkg::ST_TAIL:     if (sts_i.k_last) state_d = salb_pkg::ST_SHIFT;
      salb_pkg::ST_SHIFT:    if (sts_i.scan_done) state_d = salb_pkg::ST_CLR;
      salb_pkg::ST_CLR:      if (sts_i.i_last) state_d = salb_pkg::ST_CNT_RD;
      salb_pkg::ST_CNT_RD:   state_d = salb_pkg::ST_CNT_BK;
      salb_pkg::ST_CNT_BK:   state_d = salb_pkg::ST_CNT_WR;
      salb_pkg::ST_CNT_WR: begin
        state_d = sts_i.i_last ? salb_pkg::ST_SUM_RD : salb_pkg::ST_CNT_RD;
      end
      salb_pkg::ST_SUM_RD:   state_d = salb_pkg::ST_SUM_WR;
      salb_pkg::ST_SUM_WR: begin
        state_d = sts_i.i_last ? salb_pkg::ST_PL_RD : salb_pkg::ST_SUM_RD;
      end
      salb_pkg::ST_PL_RD:    state_d = salb_pkg::ST_PL_RANK;
      salb_pkg::ST_PL_RANK:  state_d = salb_pkg::ST_PL_BK;
      salb_pkg::ST_PL_BK:    state_d = salb_pkg::ST_PL_WR;
      salb_pkg::ST_PL_WR: begin
        state_d = sts_i.i_last ? salb_pkg::ST_COPY : salb_pkg::ST_PL_RD;
      end
      salb_pkg::ST_COPY:     if (sts_i.scan_done) state_d = salb_pkg::ST_RK_RD;
      salb_pkg::ST_RK_RD:    state_d = salb_pkg::ST_RK_A;
      salb_pkg::ST_RK_A:     state_d = salb_pkg::ST_RK_B;
      salb_pkg::ST_RK_B:     state_d = salb_pkg::ST_RK_WR;
      salb_pkg::ST_RK_WR: begin
        state_d = sts_i.i_last ? salb_pkg::ST_CHK_RD : salb_pkg::ST_RK_RD;
      end
      salb_pkg::ST_KS_RD:    state_d = salb_pkg::ST_KS_R;
      salb_pkg::ST_KS_R: begin
        if (!sts_i.rank_zero) begin
          state_d = salb_pkg::ST_KS_P;
        end else begin
          state_d = sts_i.i_last ? salb_pkg::ST_OUT_WAIT : salb_pkg::ST_KS_RD;
        end
      end
      salb_pkg::ST_KS_P:     state_d = salb_pkg::ST_KS_T0;
      salb_pkg::ST_KS_T0: begin
        state_d = sts_i.ext_ok ? salb_pkg::ST_KS_T1 : salb_pkg::ST_KS_WR;
      end
      salb_pkg::ST_KS_T1:    state_d = salb_pkg::ST_KS_T2;
      salb_pkg::ST_KS_T2: begin
        state_d = sts_i.sym_eq ? salb_pkg::ST_KS_T0 : salb_pkg::ST_KS_WR;
      end
      salb_pkg::ST_KS_WR: begin
        state_d = sts_i.i_last ? salb_pkg::ST_OUT_WAIT : salb_pkg::ST_KS_RD;
      end
      salb_pkg::ST_OUT_WAIT: if (!sts_i.out_busy) state_d = salb_pkg::ST_OUT_LOAD;
      salb_pkg::ST_OUT_LOAD: begin
        state_d = sts_i.i_last ? salb_pkg::ST_LOAD : salb_pkg::ST_OUT_WAIT;
      end
      default:               state_d = salb_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o.step = state_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= salb_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/salb_dp.sv
// salb_dp: counters, working registers, the six working rams and the result register
// depends on salb_pkg and salb_ram
module salb_dp #(
  parameter int unsigned MAX_LEN     = 64,
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  salb_pkg::cmd_t               cmd_i,
  output salb_pkg::sts_t               sts_o,
  input  logic [salb_pkg::SymInW-1:0]  symbol_i,
  input  logic                         final_symbol_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  output logic [salb_pkg::OutW-1:0]    suffix_start_o,
  output logic [salb_pkg::OutW-1:0]    lcp_next_o,
  output logic                         last_entry_o,
  output logic                         truncated_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i
);

  localparam int unsigned IW = $clog2(MAX_LEN);
  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned KW = LW + 1;
  localparam int unsigned SB = SYMBOL_BITS;
  localparam int unsigned XW = (SB > salb_pkg::SymInW) ? SB : salb_pkg::SymInW;

  salb_pkg::state_e step;
  assign step = cmd_i.step;

  // ram ports
  logic          txt_we, txt_re, ord_we, ord_re, rnk_we, rnk_re;
  logic          scr_we, scr_re, bkt_we, bkt_re, lcp_we, lcp_re;
  logic [IW-1:0] txt_wa, txt_ra, ord_wa, ord_ra, rnk_wa, rnk_ra;
  logic [IW-1:0] scr_wa, scr_ra, bkt_wa, bkt_ra, lcp_wa, lcp_ra;
  logic [SB-1:0] txt_wd, txt_rd;
  logic [IW-1:0] ord_wd, ord_rd, rnk_wd, rnk_rd, scr_wd, scr_rd, lcp_wd, lcp_rd;
  logic [LW-1:0] bkt_wd, bkt_rd;

  // registers
  logic [LW-1:0] len_q, len_d, i_q, i_d, j_q, j_d, less_q, less_d, eqb_q, eqb_d;
  logic [LW-1:0] m_q, m_d, acc_q, acc_d, h_q, h_d, sa2_q, sa2_d;
  logic [KW-1:0] k_q, k_d;
  logic          ovf_q, ovf_d, pv_q, pv_d, dn_q, dn_d, sbv_q, sbv_d;
  logic [LW-1:0] pj_q, pj_d;
  logic [SB-1:0] si_q, si_d, x_q, x_d;
  logic [IW-1:0] b_q, b_d, sb1_q, sb1_d, sa1_q, sa1_d, rprev_q, rprev_d;
  logic [IW-1:0] kr_q, kr_d, p_q, p_d;
  logic          ov_q, ov_d, olast_q, olast_d, otrunc_q, otrunc_d;
  logic [IW-1:0] ostart_q, ostart_d, olcp_q, olcp_d;

  // derived values
  logic [XW-1:0] sym_x;
  logic [SB-1:0] sym_w;
  logic          in_fire, i_last, k_last, sc_last, scan_done, len_full;
  logic [LW-1:0] sc_idx, i_next_n, i_next_k, nm1, sb2_w, pos_w;
  logic [KW-1:0] len_k, bk_sum, ih_sum, ph_sum, tail_w, shift_w;
  logic          bk_ok, ext_ok, differ;
  logic [IW-1:0] r_new;

  assign sym_x    = XW'(symbol_i);
  assign sym_w    = sym_x[SB-1:0];
  assign len_full = (len_q == LW'(MAX_LEN));
  assign in_fire  = in_valid_i && (step == salb_pkg::ST_LOAD);
  assign len_k    = KW'(len_q);
  assign nm1      = len_q - LW'(1);
  assign i_last   = (KW'(i_q) + KW'(1)) == len_k;
  assign k_last   = (KW'(i_q) + KW'(1)) == k_q;
  assign i_next_n = i_last ? '0 : i_q + LW'(1);
  assign i_next_k = k_last ? '0 : i_q + LW'(1);
  assign sc_idx   = (step == salb_pkg::ST_A_SCAN) ? j_q : i_q;
  assign sc_last  = (KW'(sc_idx) + KW'(1)) == len_k;
  assign scan_done = dn_q && !pv_q;
  assign pos_w    = less_q + eqb_q;
  assign tail_w   = len_k - k_q + KW'(i_q);
  assign shift_w  = KW'(ord_rd) - k_q;
  assign bk_sum   = KW'(b_q) + k_q;
  assign bk_ok    = bk_sum < len_k;
  assign sb2_w    = sbv_q ? LW'(scr_rd) + LW'(1) : '0;
  assign differ   = (sa1_q != sb1_q) || (sa2_q != sb2_w);
  assign r_new    = (i_q == '0) ? '0 : rprev_q + IW'(differ);
  assign ih_sum   = KW'(i_q) + KW'(h_q);
  assign ph_sum   = KW'(p_q) + KW'(h_q);
  assign ext_ok   = (ih_sum < len_k) && (ph_sum < len_k);

  // ram control per step
  always_comb begin
    txt_we = 1'b0; txt_re = 1'b0; txt_wa = '0; txt_ra = '0; txt_wd = sym_w;
    ord_we = 1'b0; ord_re = 1'b0; ord_wa = '0; ord_ra = '0; ord_wd = '0;
    rnk_we = 1'b0; rnk_re = 1'b0; rnk_wa = '0; rnk_ra = '0; rnk_wd = '0;
    scr_we = 1'b0; scr_re = 1'b0; scr_wa = '0; scr_ra = '0; scr_wd = '0;
    bkt_we = 1'b0; bkt_re = 1'b0; bkt_wa = '0; bkt_ra = '0; bkt_wd = '0;
    lcp_we = 1'b0; lcp_re = 1'b0; lcp_wa = '0; lcp_ra = '0; lcp_wd = '0;
    case (step)
      salb_pkg::ST_LOAD: begin
        txt_we = in_fire && !len_full;
        txt_wa = len_q[IW-1:0];
      end
      salb_pkg::ST_A_RD: begin
        txt_re = 1'b1;
        txt_ra = i_q[IW-1:0];
      end
      salb_pkg::ST_A_SCAN: begin
        txt_re = !dn_q;
        txt_ra = j_q[IW-1:0];
      end
      salb_pkg::ST_A_WR: begin
        ord_we = 1'b1;
        ord_wa = pos_w[IW-1:0];
        ord_wd = i_q[IW-1:0];
        rnk_we = 1'b1;
        rnk_wa = i_q[IW-1:0];
        rnk_wd = less_q[IW-1:0];
      end
      salb_pkg::ST_CHK_RD: begin
        ord_re = 1'b1;
        ord_ra = nm1[IW-1:0];
      end
      salb_pkg::ST_CHK_RANK: begin
        rnk_re = 1'b1;
        rnk_ra = ord_rd;
      end
      salb_pkg::ST_TAIL: begin
        scr_we = 1'b1;
        scr_wa = m_q[IW-1:0];
        scr_wd = tail_w[IW-1:0];
      end
      salb_pkg::ST_SHIFT: begin
        ord_re = !dn_q;
        ord_ra = i_q[IW-1:0];
        scr_we = pv_q && (KW'(ord_rd) >= k_q);
        scr_wa = m_q[IW-1:0];
        scr_wd = shift_w[IW-1:0];
      end
      salb_pkg::ST_CLR: begin
        bkt_we = 1'b1;
        bkt_wa = i_q[IW-1:0];
      end
      salb_pkg::ST_CNT_RD: begin
        rnk_re = 1'b1;
        rnk_ra = i_q[IW-1:0];
      end
      salb_pkg::ST_CNT_BK: begin
        bkt_re = 1'b1;
        bkt_ra = rnk_rd;
      end
      salb_pkg::ST_CNT_WR: begin
        bkt_we = 1'b1;
        bkt_wa = rnk_rd;
        bkt_wd = bkt_rd + LW'(1);
      end
      salb_pkg::ST_SUM_RD: begin
        bkt_re = 1'b1;
        bkt_ra = i_q[IW-1:0];
      end
      salb_pkg::ST_SUM_WR: begin
        bkt_we = 1'b1;
        bkt_wa = i_q[IW-1:0];
        bkt_wd = acc_q + bkt_rd;
      end
      salb_pkg::ST_PL_RD: begin
        scr_re = 1'b1;
        scr_ra = IW'(nm1 - i_q);
      end
      salb_pkg::ST_PL_RANK: begin
        rnk_re = 1'b1;
        rnk_ra = scr_rd;
      end
      salb_pkg::ST_PL_BK: begin
        bkt_re = 1'b1;
        bkt_ra = rnk_rd;
      end
      salb_pkg::ST_PL_WR: begin
        bkt_we = 1'b1;
        bkt_wa = rnk_rd;
        bkt_wd = bkt_rd - LW'(1);
        ord_we = 1'b1;
        ord_wa = IW'(bkt_rd - LW'(1));
        ord_wd = scr_rd;
      end
      salb_pkg::ST_COPY: begin
        rnk_re = !dn_q;
        rnk_ra = i_q[IW-1:0];
        scr_we = pv_q;
        scr_wa = pj_q[IW-1:0];
        scr_wd = rnk_rd;
      end
      salb_pkg::ST_RK_RD: begin
        ord_re = 1'b1;
        ord_ra = i_q[IW-1:0];
      end
      salb_pkg::ST_RK_A: begin
        scr_re = 1'b1;
        scr_ra = ord_rd;
      end
      salb_pkg::ST_RK_B: begin
        scr_re = bk_ok;
        scr_ra = bk_sum[IW-1:0];
      end
      salb_pkg::ST_RK_WR: begin
        rnk_we = 1'b1;
        rnk_wa = b_q;
        rnk_wd = r_new;
      end
      salb_pkg::ST_KS_RD: begin
        rnk_re = 1'b1;
        rnk_ra = i_q[IW-1:0];
      end
      salb_pkg::ST_KS_R: begin
        ord_re = (rnk_rd != '0);
        ord_ra = rnk_rd - IW'(1);
      end
      salb_pkg::ST_KS_T0: begin
        txt_re = ext_ok;
        txt_ra = ih_sum[IW-1:0];
      end
      salb_pkg::ST_KS_T1: begin
        txt_re = 1'b1;
        txt_ra = ph_sum[IW-1:0];
      end
      salb_pkg::ST_KS_WR: begin
        lcp_we = 1'b1;
        lcp_wa = kr_q - IW'(1);
        lcp_wd = h_q[IW-1:0];
      end
      salb_pkg::ST_OUT_WAIT: begin
        ord_re = 1'b1;
        ord_ra = i_q[IW-1:0];
        lcp_re = 1'b1;
        lcp_ra = i_q[IW-1:0];
      end
      default: begin
      end
    endcase
  end

  // register updates per step
  always_comb begin
    len_d = len_q; ovf_d = ovf_q; i_d = i_q; j_d = j_q; pj_d = pj_q;
    pv_d = pv_q; dn_d = dn_q; less_d = less_q; eqb_d = eqb_q; si_d = si_q;
    k_d = k_q; m_d = m_q; acc_d = acc_q; b_d = b_q; sb1_d = sb1_q; sbv_d = sbv_q;
    sa1_d = sa1_q; sa2_d = sa2_q; rprev_d = rprev_q; h_d = h_q; kr_d = kr_q;
    p_d = p_q; x_d = x_q;
    ostart_d = ostart_q; olcp_d = olcp_q; olast_d = olast_q; otrunc_d = otrunc_q;
    ov_d = ov_q && out_stall_i;

    // shared pipelined scan: issue one read a cycle, consume the previous one
    if (step == salb_pkg::ST_A_SCAN || step == salb_pkg::ST_SHIFT ||
        step == salb_pkg::ST_COPY) begin
      if (!dn_q) begin
        pv_d = 1'b1;
        pj_d = sc_idx;
        dn_d = sc_last;
        if (step == salb_pkg::ST_A_SCAN) begin
          j_d = sc_last ? '0 : j_q + LW'(1);
        end else begin
          i_d = sc_last ? '0 : i_q + LW'(1);
        end
      end else begin
        pv_d = 1'b0;
        if (!pv_q) begin
          dn_d = 1'b0;
        end
      end
    end

    case (step)
      salb_pkg::ST_LOAD: begin
        k_d = KW'(1);
        if (in_fire) begin
          if (!len_full) begin
            len_d = len_q + LW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      salb_pkg::ST_A_LATCH: begin
        si_d   = txt_rd;
        less_d = '0;
        eqb_d  = '0;
        j_d    = '0;
        pv_d   = 1'b0;
        dn_d   = 1'b0;
      end
      salb_pkg::ST_A_SCAN: begin
        if (pv_q) begin
          if (txt_rd < si_q) begin
            less_d = less_q + LW'(1);
          end
          if (txt_rd == si_q && pj_q < i_q) begin
            eqb_d = eqb_q + LW'(1);
          end
        end
      end
      salb_pkg::ST_A_WR:     i_d = i_next_n;
      salb_pkg::ST_CHK_RD:   m_d = '0;
      salb_pkg::ST_CHK_TEST: h_d = '0;
      salb_pkg::ST_TAIL: begin
        m_d = m_q + LW'(1);
        i_d = i_next_k;
      end
      salb_pkg::ST_SHIFT: begin
        if (pv_q && KW'(ord_rd) >= k_q) begin
          m_d = m_q + LW'(1);
        end
      end
      salb_pkg::ST_CLR: begin
        acc_d = '0;
        i_d   = i_next_n;
      end
      salb_pkg::ST_CNT_WR:   i_d = i_next_n;
      salb_pkg::ST_SUM_WR: begin
        acc_d = acc_q + bkt_rd;
        i_d   = i_next_n;
      end
      salb_pkg::ST_PL_WR:    i_d = i_next_n;
      salb_pkg::ST_RK_A:     b_d = ord_rd;
      salb_pkg::ST_RK_B: begin
        sb1_d = scr_rd;
        sbv_d = bk_ok;
      end
      salb_pkg::ST_RK_WR: begin
        rprev_d = r_new;
        sa1_d   = sb1_q;
        sa2_d   = sb2_w;
        i_d     = i_next_n;
        if (i_last) begin
          k_d = k_q << 1;
        end
      end
      salb_pkg::ST_KS_R: begin
        kr_d = rnk_rd;
        if (rnk_rd == '0) begin
          h_d = '0;
          i_d = i_next_n;
        end else if (h_q != '0) begin
          h_d = h_q - LW'(1);
        end
      end
      salb_pkg::ST_KS_P:     p_d = ord_rd;
      salb_pkg::ST_KS_T1:    x_d = txt_rd;
      salb_pkg::ST_KS_T2: begin
        if (txt_rd == x_q) begin
          h_d = h_q + LW'(1);
        end
      end
      salb_pkg::ST_KS_WR:    i_d = i_next_n;
      salb_pkg::ST_OUT_LOAD: begin
        ov_d     = 1'b1;
        ostart_d = ord_rd;
        olcp_d   = i_last ? '0 : lcp_rd;
        olast_d  = i_last;
        otrunc_d = ovf_q;
        i_d      = i_next_n;
        if (i_last) begin
          len_d = '0;
          ovf_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ovf_q <= 1'b0;
      i_q   <= '0;
      j_q   <= '0;
      pv_q  <= 1'b0;
      dn_q  <= 1'b0;
      k_q   <= KW'(1);
      m_q   <= '0;
      ov_q  <= 1'b0;
    end else begin
      len_q <= len_d;
      ovf_q <= ovf_d;
      i_q   <= i_d;
      j_q   <= j_d;
      pv_q  <= pv_d;
      dn_q  <= dn_d;
      k_q   <= k_d;
      m_q   <= m_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pj_q     <= pj_d;
    less_q   <= less_d;
    eqb_q    <= eqb_d;
    si_q     <= si_d;
    acc_q    <= acc_d;
    b_q      <= b_d;
    sb1_q    <= sb1_d;
    sbv_q    <= sbv_d;
    sa1_q    <= sa1_d;
    sa2_q    <= sa2_d;
    rprev_q  <= rprev_d;
    h_q      <= h_d;
    kr_q     <= kr_d;
    p_q      <= p_d;
    x_q      <= x_d;
    ostart_q <= ostart_d;
    olcp_q   <= olcp_d;
    olast_q  <= olast_d;
    otrunc_q <= otrunc_d;
  end

  salb_ram #(.Width(SB), .Depth(MAX_LEN)) u_text (
    .clk_i, .we_i(txt_we), .waddr_i(txt_wa), .wdata_i(txt_wd),
    .re_i(txt_re), .raddr_i(txt_ra), .rdata_o(txt_rd)
  );
  salb_ram #(.Width(IW), .Depth(MAX_LEN)) u_order (
    .clk_i, .we_i(ord_we), .waddr_i(ord_wa), .wdata_i(ord_wd),
    .re_i(ord_re), .raddr_i(ord_ra), .rdata_o(ord_rd)
  );
  salb_ram #(.Width(IW), .Depth(MAX_LEN)) u_rank (
    .clk_i, .we_i(rnk_we), .waddr_i(rnk_wa), .wdata_i(rnk_wd),
    .re_i(rnk_re), .raddr_i(rnk_ra), .rdata_o(rnk_rd)
  );
  salb_ram #(.Width(IW), .Depth(MAX_LEN)) u_scratch (
    .clk_i, .we_i(scr_we), .waddr_i(scr_wa), .wdata_i(scr_wd),
    .re_i(scr_re), .raddr_i(scr_ra), .rdata_o(scr_rd)
  );
  salb_ram #(.Width(LW), .Depth(MAX_LEN)) u_bucket (
    .clk_i, .we_i(bkt_we), .waddr_i(bkt_wa), .wdata_i(bkt_wd),
    .re_i(bkt_re), .raddr_i(bkt_ra), .rdata_o(bkt_rd)
  );
  salb_ram #(.Width(IW), .Depth(MAX_LEN)) u_lcp (
    .clk_i, .we_i(lcp_we), .waddr_i(lcp_wa), .wdata_i(lcp_wd),
    .re_i(lcp_re), .raddr_i(lcp_ra), .rdata_o(lcp_rd)
  );

  always_comb begin
    sts_o.in_fire   = in_fire;
    sts_o.in_final  = final_symbol_i;
    sts_o.i_last    = i_last;
    sts_o.k_last    = k_last;
    sts_o.scan_done = scan_done;
    // first-symbol ranks count smaller symbols, not distinct ones, so the
    // top-rank test only proves a full order once a round has rebuilt the ranks
    sts_o.sorted    = ((k_q != KW'(1)) && (KW'(rnk_rd) == KW'(nm1))) || (k_q >= len_k);
    sts_o.rank_zero = (rnk_rd == '0);
    sts_o.ext_ok    = ext_ok;
    sts_o.sym_eq    = (txt_rd == x_q);
    sts_o.out_busy  = ov_q;
  end

  assign in_stall_o     = (step != salb_pkg::ST_LOAD);
  assign out_valid_o    = ov_q;
  assign suffix_start_o = salb_pkg::OutW'(ostart_q);
  assign lcp_next_o     = salb_pkg::OutW'(olcp_q);
  assign last_entry_o   = olast_q;
  assign truncated_o    = otrunc_q;

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> len_full)
    else $error("overflow flag set with room left in text store");

  a_final_starts_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && final_symbol_i) |=> in_stall_o)
    else $error("build did not start after final symbol");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step == salb_pkg::ST_A_WR) |-> (pos_w < len_q))
    else $error("initial sort position out of range");

  a_out_only_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step == salb_pkg::ST_OUT_LOAD) |-> !ov_q)
    else $error("result register overwritten before it was taken");

endmodule

### src/suffix_array_lcp_builder.sv
// suffix_array_lcp_builder: top level of the suffix array and lcp builder
// depends on salb_pkg, salb_ctrl, salb_dp (and salb_ram through salb_dp)
//
// symbols stream in one transaction per cycle while the block is loading; up to
// MAX_LEN are kept, later ones are dropped and flag the run as truncated. the
// transaction with final_symbol_i set starts the build and the input stalls until
// the last result has been loaded into the output register. the build is run by a
// sequencer over six working rams (text, order, rank, scratch, bucket, lcp), each
// with one write and one read port, one access per ram per cycle, so its length is
// set by ram accesses: the first-symbol ranking scans all n stored symbols for each
// symbol, then come the prefix-doubling rounds (at least one round when n > 1, at
// most about log2(n), fewer when all ranks become distinct early), and the lcp
// pass extends each match one symbol at a time (under 2*n matches in total).
// results then leave in sorted suffix order, each one loaded into the output
// register only after the previous one has been taken. lcp_next_o is 0 on the
// entry that carries last_entry_o.
module suffix_array_lcp_builder #(
  parameter int unsigned MAX_LEN     = 64,
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input transactions
  input  logic [salb_pkg::SymInW-1:0] symbol_i,
  input  logic                        final_symbol_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  // result transactions
  output logic [salb_pkg::OutW-1:0]   suffix_start_o,
  output logic [salb_pkg::OutW-1:0]   lcp_next_o,
  output logic                        last_entry_o,
  output logic                        truncated_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i
);

  salb_pkg::cmd_t cmd;
  salb_pkg::sts_t sts;

  // sequencer: owns the step, reacts to datapath status
  salb_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  // datapath: rams, counters, compare logic and the result register
  salb_dp #(
    .MAX_LEN     (MAX_LEN),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i          (cmd),
    .sts_o          (sts),
    .symbol_i,
    .final_symbol_i,
    .in_valid_i,
    .in_stall_o,
    .suffix_start_o,
    .lcp_next_o,
    .last_entry_o,
    .truncated_o,
    .out_valid_o,
    .out_stall_i
  );

endmodule
